>>> sv/ddo_pkg.sv
package ddo_pkg;

   localparam int CORDIC_STEPS = 24;
   localparam int STEP_W = 5;
   localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
   localparam logic signed [16:0] DELTA_LIMIT = 17'sd32767;
   localparam logic [23:0] DIST_RESET = 24'd979600;
   localparam logic [23:0] HEAD_RESET = 24'd402240;

   localparam logic CSR_DISTANCE = 1'b0;
   localparam logic CSR_HEADING = 1'b1;

   typedef struct packed {
      logic load;
      logic iterate;
      logic finish_trig;
      logic mult_x;
      logic mult_y;
      logic accumulate;
      logic [STEP_W-1:0] step;
   } cmd_type;

   function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
      logic [31:0] r;
      case (i)
         5'd0: r = 32'd536870912;
         5'd1: r = 32'd316933406;
         5'd2: r = 32'd167458907;
         5'd3: r = 32'd85004756;
         5'd4: r = 32'd42667331;
         5'd5: r = 32'd21354465;
         5'd6: r = 32'd10679838;
         5'd7: r = 32'd5340245;
         5'd8: r = 32'd2670163;
         5'd9: r = 32'd1335087;
         5'd10: r = 32'd667544;
         5'd11: r = 32'd333772;
         5'd12: r = 32'd166886;
         5'd13: r = 32'd83443;
         5'd14: r = 32'd41722;
         5'd15: r = 32'd20861;
         5'd16: r = 32'd10430;
         5'd17: r = 32'd5215;
         5'd18: r = 32'd2608;
         5'd19: r = 32'd1304;
         5'd20: r = 32'd652;
         5'd21: r = 32'd326;
         5'd22: r = 32'd163;
         5'd23: r = 32'd81;
         default: r = 32'd0;
      endcase
      return r;
   endfunction

endpackage

>>> sv/ddo_stream_if.sv
interface ddo_stream_if #(
   parameter int W = 64
);
   logic valid;
   logic ready;
   logic [W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> sv/differential_drive_odometry.sv
// From input transfer to result valid, an item passes the CORDIC, TRIG, MX, MY and ACC states in turn.
// One item is processed at a time, using the 24-step shared CORDIC loop.
// The next item is taken only after the result transfer.
// Reset (synchronous, active high) clears position, heading, last counts, and
// restores the register defaults.
module differential_drive_odometry #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic clock,
   input  logic reset,
   ddo_stream_if.sink   req_if,
   ddo_stream_if.source rsp_if,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [23:0] csr_data
);

   ddo_pkg::cmd_type cmd;
   logic busy, out_valid;
   logic signed [63:0] px, py;
   logic [31:0] hd;

   assign req_if.ready = !busy;

   ddo_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .start(req_if.valid && !busy),
      .out_taken(rsp_if.ready),
      .busy(busy), .out_valid(out_valid), .cmd(cmd)
   );

   ddo_datapath #(.TRIG_FRAC_BITS(TRIG_FRAC_BITS)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .left_count(req_if.data[31:0]), .right_count(req_if.data[63:32]),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .pos_x(px), .pos_y(py), .heading_angle(hd)
   );

   assign rsp_if.valid = out_valid;
   assign rsp_if.data = {hd, py, px};

endmodule

>>> sv/ddo_ctrl.sv
module ddo_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic start,
   input  logic out_taken,
   output logic busy,
   output logic out_valid,
   output ddo_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      S_IDLE, S_CORDIC, S_TRIG, S_MX, S_MY, S_ACC, S_OUT
   } state_type;

   state_type state_ff, state_in;
   logic [ddo_pkg::STEP_W-1:0] step_ff, step_in;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd = '0;
      cmd.step = step_ff;
      case (state_ff)
         S_IDLE: begin
            step_in = '0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CORDIC;
            end
         end
         S_CORDIC: begin
            cmd.iterate = 1'b1;
            step_in = step_ff + 1'b1;
            if (step_ff == ddo_pkg::STEP_W'(ddo_pkg::CORDIC_STEPS - 1)) state_in = S_TRIG;
         end
         S_TRIG: begin
            cmd.finish_trig = 1'b1;
            state_in = S_MX;
         end
         S_MX: begin
            cmd.mult_x = 1'b1;
            state_in = S_MY;
         end
         S_MY: begin
            cmd.mult_y = 1'b1;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.accumulate = 1'b1;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_taken) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign out_valid = (state_ff == S_OUT);

endmodule

>>> sv/ddo_datapath.sv
module ddo_datapath #(
   parameter int TRIG_FRAC_BITS = 15
) (
   input  logic clock,
   input  logic reset,
   input  ddo_pkg::cmd_type cmd,
   input  logic [31:0] left_count,
   input  logic [31:0] right_count,
   input  logic csr_write,
   input  logic [0:0] csr_index,
   input  logic [23:0] csr_data,
   output logic signed [63:0] pos_x,
   output logic signed [63:0] pos_y,
   output logic [31:0] heading_angle
);

   localparam int SH = 30 - TRIG_FRAC_BITS;
   localparam int TW = TRIG_FRAC_BITS + 2;

   logic [23:0] dist_reg_ff, head_reg_ff;
   logic [31:0] last_left_ff, last_right_ff, heading_ff;
   logic signed [63:0] acc_x_ff, acc_y_ff;
   logic signed [41:0] dist_ff;
   logic [31:0] dth_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic flip_ff;
   logic signed [TW-1:0] cos_ff, sin_ff;
   logic signed [63:0] prod_ff, dx_ff;

   function automatic logic signed [16:0] clamp_delta(input logic [31:0] d);
      logic signed [31:0] s;
      s = $signed(d);
      if (s > 32'sd32767) return ddo_pkg::DELTA_LIMIT;
      if (s < -32'sd32767) return -ddo_pkg::DELTA_LIMIT;
      return s[16:0];
   endfunction

   function automatic logic signed [TW-1:0] to_trig(input logic signed [33:0] q);
      logic signed [33:0] r;
      logic signed [33:0] one;
      r = (q + (34'sd1 <<< (SH - 1))) >>> SH;
      one = 34'sd1 <<< TRIG_FRAC_BITS;
      if (r > one) r = one;
      if (r < -one) r = -one;
      return r[TW-1:0];
   endfunction

   function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic signed [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      return s[63:0];
   endfunction

   logic signed [16:0] dl, dr;
   logic signed [17:0] dsum, ddiff;
   logic signed [42:0] dprod;
   logic signed [63:0] ddiff64;
   logic signed [33:0] xs, ys;
   logic [31:0] hflip;
   logic signed [TW-1:0] tsel;
   logic signed [64:0] mul_full;
   logic signed [63:0] dy_now;

   always_comb begin
      dl = clamp_delta(left_count - last_left_ff);
      dr = clamp_delta(right_count - last_right_ff);
      dsum = 18'(dl) + 18'(dr);
      ddiff = 18'(dr) - 18'(dl);
      dprod = 43'(dsum) * $signed({19'd0, dist_reg_ff});
      ddiff64 = 64'(ddiff);
      xs = cx_ff >>> cmd.step;
      ys = cy_ff >>> cmd.step;
      hflip = heading_ff;
      if ($signed(heading_ff) > 32'sd1073741824 || $signed(heading_ff) < -32'sd1073741824)
         hflip = heading_ff ^ 32'h80000000;
      tsel = cmd.mult_x ? cos_ff : sin_ff;
      mul_full = 65'(dist_ff) * 65'(tsel);
      dy_now = (prod_ff + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_reg_ff <= ddo_pkg::DIST_RESET;
         head_reg_ff <= ddo_pkg::HEAD_RESET;
         last_left_ff <= '0;
         last_right_ff <= '0;
         heading_ff <= '0;
         acc_x_ff <= '0;
         acc_y_ff <= '0;
      end else begin
         if (csr_write) begin
            if (csr_index == ddo_pkg::CSR_DISTANCE) dist_reg_ff <= csr_data;
            else head_reg_ff <= csr_data;
         end
         if (cmd.load) begin
            last_left_ff <= left_count;
            last_right_ff <= right_count;
         end
         if (cmd.accumulate) begin
            acc_x_ff <= sat_add(acc_x_ff, dx_ff);
            acc_y_ff <= sat_add(acc_y_ff, dy_now);
            heading_ff <= heading_ff + dth_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         dist_ff <= dprod[42:1];
         dth_ff <= 32'(ddiff64 * $signed({40'd0, head_reg_ff}));
         cx_ff <= 34'(ddo_pkg::CORDIC_GAIN);
         cy_ff <= '0;
         cz_ff <= 34'($signed(hflip));
         flip_ff <= (hflip != heading_ff);
      end
      if (cmd.iterate) begin
         if (!cz_ff[33]) begin
            cx_ff <= cx_ff - ys;
            cy_ff <= cy_ff + xs;
            cz_ff <= cz_ff - $signed({2'b00, ddo_pkg::atan_turn(cmd.step)});
         end else begin
            cx_ff <= cx_ff + ys;
            cy_ff <= cy_ff - xs;
            cz_ff <= cz_ff + $signed({2'b00, ddo_pkg::atan_turn(cmd.step)});
         end
      end
      if (cmd.finish_trig) begin
         cos_ff <= flip_ff ? -to_trig(cx_ff) : to_trig(cx_ff);
         sin_ff <= flip_ff ? -to_trig(cy_ff) : to_trig(cy_ff);
      end
      if (cmd.mult_x || cmd.mult_y) prod_ff <= 64'(mul_full);
      if (cmd.mult_y) dx_ff <= (prod_ff + (64'sd1 <<< (TRIG_FRAC_BITS - 1))) >>> TRIG_FRAC_BITS;
   end

   assign pos_x = acc_x_ff;
   assign pos_y = acc_y_ff;
   assign heading_angle = heading_ff;

endmodule
